### rtl/fsgs_pkg.sv
package fsgs_pkg;

  localparam int IDX_W  = 14;
  localparam int TYPE_W = 2;
  localparam int DRAW_W = 7;
  localparam int KIND_W = 3;

  localparam logic [DRAW_W-1:0] THRESH_RESET = 7'd50;

  typedef enum logic [TYPE_W-1:0] {
    CELL_AIR   = 2'd0,
    CELL_SAND  = 2'd1,
    CELL_WATER = 2'd2,
    CELL_SOLID = 2'd3
  } cell_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    MV_NONE  = 3'd0,
    MV_FELL  = 3'd1,
    MV_SWAP  = 3'd2,
    MV_LEFT  = 3'd3,
    MV_RIGHT = 3'd4
  } move_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CENTER,
    S_BELOW,
    S_LEFT,
    S_RIGHT,
    S_WR2,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [IDX_W-1:0]  cell_index;
    logic [TYPE_W-1:0] cell_type;
    logic [DRAW_W-1:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0] read_type;
    logic [IDX_W-1:0]  new_index;
    logic              moved;
    logic [KIND_W-1:0] move_kind;
  } out_item_t;

endpackage

### rtl/fsgs_cell_ram.sv
module fsgs_cell_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  fsgs_pkg::cell_t       wdata,
  input  logic [AW-1:0]         raddr,
  output fsgs_pkg::cell_t       rdata
);

  fsgs_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/fsgs_seq.sv
module fsgs_seq #(
  parameter int ROW_WIDTH  = 128,
  parameter int CELL_COUNT = 16384,
  parameter int AW         = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  fsgs_pkg::in_item_t                   in_item,
  input  logic [fsgs_pkg::DRAW_W-1:0]          threshold,
  output logic                                 busy,
  output logic                                 out_valid,
  output fsgs_pkg::out_item_t                  out_item,
  output logic                                 mem_we,
  output logic [AW-1:0]                        mem_waddr,
  output fsgs_pkg::cell_t                      mem_wdata,
  output logic [AW-1:0]                        mem_raddr,
  input  fsgs_pkg::cell_t                      mem_rdata
);

  localparam int IW    = fsgs_pkg::IDX_W;
  localparam int CW    = $clog2(CELL_COUNT + 1);
  localparam int EW    = (CW > IW + 1) ? CW : IW + 1;
  // floor(idx / ROW_WIDTH) by reciprocal, exact for all IW-bit idx
  localparam int SHIFT = IW + $clog2(ROW_WIDTH);
  localparam int RECIP = ((2 ** SHIFT) + ROW_WIDTH - 1) / ROW_WIDTH;
  localparam int MW    = IW + 2;
  localparam int PW    = SHIFT + IW;
  localparam logic [MW-1:0] RECIP_V = MW'(RECIP);
  localparam logic [AW-1:0] LAST    = AW'(CELL_COUNT - 1);
  localparam logic [EW-1:0] CC_E    = EW'(CELL_COUNT);
  localparam logic [EW-1:0] RW_E    = EW'(ROW_WIDTH);
  localparam logic [EW-1:0] RWM1_E  = EW'(ROW_WIDTH - 1);

  fsgs_pkg::seq_state_t        state_r, state_nxt;
  logic [AW-1:0]               clr_r, clr_nxt;
  logic [1:0]                  cmd_r, cmd_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  fsgs_pkg::cell_t             typ_r, typ_nxt;
  logic [fsgs_pkg::DRAW_W-1:0] draw_r, draw_nxt;
  logic [IW-1:0]               q_r, q_nxt;
  logic [EW-1:0]               below_r, below_nxt;
  logic [EW-1:0]               tgt_r, tgt_nxt;
  logic                        lok_r, lok_nxt;
  logic                        rok_r, rok_nxt;
  logic                        lf_r, lf_nxt;
  fsgs_pkg::cell_t             rd_r, rd_nxt;
  logic [IW-1:0]               nidx_r, nidx_nxt;
  fsgs_pkg::move_t             kind_r, kind_nxt;

  logic [PW-1:0] prod_c;
  logic [EW-1:0] idx_e, below_c, qrw_c, left_c, right_c;
  logic          inside_c, rfree_c, rf_c;

  assign prod_c   = PW'(in_item.cell_index) * PW'(RECIP_V);
  assign idx_e    = EW'(idx_r);
  assign below_c  = idx_e + RW_E;
  assign qrw_c    = EW'(q_r) * RW_E;
  assign left_c   = below_r - EW'(1);
  assign right_c  = below_r + EW'(1);
  assign inside_c = idx_e < CC_E;
  assign rfree_c  = (mem_rdata == fsgs_pkg::CELL_AIR) || (mem_rdata == fsgs_pkg::CELL_WATER);
  assign rf_c     = rok_r && (right_c < CC_E) && rfree_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsgs_pkg::S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    typ_r   <= typ_nxt;
    draw_r  <= draw_nxt;
    q_r     <= q_nxt;
    below_r <= below_nxt;
    tgt_r   <= tgt_nxt;
    lok_r   <= lok_nxt;
    rok_r   <= rok_nxt;
    lf_r    <= lf_nxt;
    rd_r    <= rd_nxt;
    nidx_r  <= nidx_nxt;
    kind_r  <= kind_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    typ_nxt   = typ_r;
    draw_nxt  = draw_r;
    q_nxt     = q_r;
    below_nxt = below_r;
    tgt_nxt   = tgt_r;
    lok_nxt   = lok_r;
    rok_nxt   = rok_r;
    lf_nxt    = lf_r;
    rd_nxt    = rd_r;
    nidx_nxt  = nidx_r;
    kind_nxt  = kind_r;
    mem_we    = 1'b0;
    mem_waddr = idx_e[AW-1:0];
    mem_wdata = fsgs_pkg::CELL_AIR;
    mem_raddr = idx_e[AW-1:0];

    unique case (state_r)
      fsgs_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == LAST) begin
          state_nxt = fsgs_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      fsgs_pkg::S_IDLE: begin
        mem_raddr = EW'(in_item.cell_index) >= CC_E ? '0 : AW'(EW'(in_item.cell_index));
        if (start) begin
          cmd_nxt   = in_item.command;
          idx_nxt   = in_item.cell_index;
          typ_nxt   = fsgs_pkg::cell_t'(in_item.cell_type);
          draw_nxt  = in_item.random_draw;
          q_nxt     = prod_c[PW-1:SHIFT];
          rd_nxt    = fsgs_pkg::CELL_AIR;
          nidx_nxt  = in_item.cell_index;
          kind_nxt  = fsgs_pkg::MV_NONE;
          state_nxt = fsgs_pkg::S_CENTER;
        end
      end
      fsgs_pkg::S_CENTER: begin
        // mem_rdata holds the addressed cell
        mem_raddr = below_c[AW-1:0];
        below_nxt = below_c;
        lok_nxt   = qrw_c != idx_e;
        rok_nxt   = (qrw_c + RWM1_E) != idx_e;
        state_nxt = fsgs_pkg::S_RESP;
        priority if (cmd_r == fsgs_pkg::CMD_WRITE) begin
          mem_we    = inside_c;
          mem_wdata = typ_r;
        end else if (cmd_r == fsgs_pkg::CMD_READ) begin
          if (inside_c) begin
            rd_nxt = mem_rdata;
          end
        end else if (cmd_r == fsgs_pkg::CMD_STEP && inside_c &&
                     mem_rdata == fsgs_pkg::CELL_SAND && below_c < CC_E) begin
          state_nxt = fsgs_pkg::S_BELOW;
        end else begin
          state_nxt = fsgs_pkg::S_RESP;
        end
      end
      fsgs_pkg::S_BELOW: begin
        mem_raddr = left_c[AW-1:0];
        tgt_nxt   = below_r;
        priority if (mem_rdata == fsgs_pkg::CELL_AIR) begin
          mem_we    = 1'b1;
          mem_wdata = fsgs_pkg::CELL_AIR;
          nidx_nxt  = below_r[IW-1:0];
          kind_nxt  = fsgs_pkg::MV_FELL;
          state_nxt = fsgs_pkg::S_WR2;
        end else if (mem_rdata == fsgs_pkg::CELL_WATER) begin
          mem_we    = 1'b1;
          mem_wdata = fsgs_pkg::CELL_WATER;
          nidx_nxt  = below_r[IW-1:0];
          kind_nxt  = fsgs_pkg::MV_SWAP;
          state_nxt = fsgs_pkg::S_WR2;
        end else begin
          state_nxt = fsgs_pkg::S_LEFT;
        end
      end
      fsgs_pkg::S_LEFT: begin
        mem_raddr = right_c[AW-1:0];
        lf_nxt    = lok_r && rfree_c;
        state_nxt = fsgs_pkg::S_RIGHT;
      end
      fsgs_pkg::S_RIGHT: begin
        state_nxt = fsgs_pkg::S_WR2;
        mem_we    = 1'b1;
        mem_wdata = fsgs_pkg::CELL_AIR;
        priority if (lf_r && (!rf_c || draw_r <= threshold)) begin
          tgt_nxt  = left_c;
          nidx_nxt = left_c[IW-1:0];
          kind_nxt = fsgs_pkg::MV_LEFT;
        end else if (rf_c) begin
          tgt_nxt  = right_c;
          nidx_nxt = right_c[IW-1:0];
          kind_nxt = fsgs_pkg::MV_RIGHT;
        end else begin
          mem_we    = 1'b0;
          state_nxt = fsgs_pkg::S_RESP;
        end
      end
      fsgs_pkg::S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_r[AW-1:0];
        mem_wdata = fsgs_pkg::CELL_SAND;
        state_nxt = fsgs_pkg::S_RESP;
      end
      fsgs_pkg::S_RESP: begin
        state_nxt = fsgs_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fsgs_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = state_r != fsgs_pkg::S_IDLE;
  assign out_valid = state_r == fsgs_pkg::S_RESP;

  always_comb begin
    out_item.read_type = rd_r;
    out_item.new_index = nidx_r;
    out_item.moved     = kind_r != fsgs_pkg::MV_NONE;
    out_item.move_kind = kind_r;
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fsgs_pkg::S_IDLE |-> !mem_we)
    else $error("cell write while idle");

  a_wr2_after_wr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fsgs_pkg::S_WR2 |-> $past(mem_we) && $past(mem_waddr) == idx_e[AW-1:0])
    else $error("second write of a move without vacating the grain cell");

  a_move_changes_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.moved |-> out_item.new_index != idx_r)
    else $error("move reported without index change");

  a_read_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cmd_r != fsgs_pkg::CMD_READ |-> out_item.read_type == fsgs_pkg::CELL_AIR)
    else $error("read_type set on a non-read command");

  a_step_only_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cmd_r != fsgs_pkg::CMD_STEP |-> !out_item.moved)
    else $error("move reported on a non-step command");
`endif

endmodule

### rtl/falling_sand_grain_step.sv
// Falling-sand grid engine: a CELL_COUNT-cell grid of 2-bit types (air, sand,
// water, solid) in rows of ROW_WIDTH, kept in one single-port-write RAM.
// Commands enter on in_item when start is high and busy is low: write a
// cell, read a cell, or step the sand grain at an index.
// Every command yields exactly one result on out_item, valid for the single
// cycle in which out_valid is high. The receiver cannot stall; results are
// never held.
// Write, read, undefined commands and steps that stop early pass from S_CENTER
// straight to S_RESP; a step that reads the cell below and both diagonals and
// then writes two cells passes S_CENTER, S_BELOW, S_LEFT, S_RIGHT, S_WR2 and
// S_RESP. busy drops the cycle after out_valid, so a new command is taken only
// once the last one has finished.
// cfg_we/cfg_wdata load thresh_r (reset 50) at any edge while rst_n is high.
// After reset the RAM is swept to air, one cell per cycle, over all CELL_COUNT
// cells (16384 by default); busy stays high during the sweep.
module falling_sand_grain_step #(
  parameter int ROW_WIDTH  = 128,
  parameter int CELL_COUNT = 16384
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  fsgs_pkg::in_item_t            in_item,
  output logic                          busy,
  output logic                          out_valid,
  output fsgs_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [fsgs_pkg::DRAW_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(CELL_COUNT);

  logic [fsgs_pkg::DRAW_W-1:0] thresh_r, thresh_nxt;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [AW-1:0]               mem_raddr;
  fsgs_pkg::cell_t             mem_wdata;
  fsgs_pkg::cell_t             mem_rdata;

  assign thresh_nxt = cfg_we ? cfg_wdata : thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= fsgs_pkg::THRESH_RESET;
    end else begin
      thresh_r <= thresh_nxt;
    end
  end

  fsgs_cell_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fsgs_seq #(
    .ROW_WIDTH  (ROW_WIDTH),
    .CELL_COUNT (CELL_COUNT),
    .AW         (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .threshold (thresh_r),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
